>>> rtl/lcv_pkg.sv
// Shared types and constants for the LC value calculator.
package lcv_pkg;

  localparam int unsigned BIG_W = 256;
  localparam int unsigned LIMBS = BIG_W / 32;

  localparam logic [31:0] FOUR_PI_SQ_Q24 = 32'd662337939;
  localparam logic [31:0] LIM0 = 32'd999;
  localparam logic [31:0] LIM1 = 32'd999000;
  localparam logic [31:0] LIM2 = 32'd999000000;
  localparam logic [31:0] SC0 = 32'd1;
  localparam logic [31:0] SC1 = 32'd1000;
  localparam logic [31:0] SC2 = 32'd1000000;
  localparam logic [31:0] SC3 = 32'd1000000000;
  localparam logic [31:0] E9 = 32'd1000000000;
  localparam logic [31:0] E6 = 32'd1000000;
  localparam logic [31:0] Q24_ONE = 32'd16777216;
  localparam logic [31:0] HUNDRED = 32'd100;

  localparam logic [2:0] UNIT_NH = 3'd3;
  localparam logic [2:0] UNIT_PF = 3'd7;

  localparam logic [1:0] REG_OPEN = 2'd0;
  localparam logic [1:0] REG_LOADED = 2'd1;
  localparam logic [1:0] REG_CCAL = 2'd2;
  localparam logic [1:0] REG_GATE = 2'd3;

  localparam logic OP_CAP = 1'b0;
  localparam logic OP_IND = 1'b1;

  typedef struct packed {
    logic [15:0] f1;
    logic [15:0] f2;
    logic [15:0] cc;
    logic [9:0]  gate;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic        err;
    logic        neg;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] s3;
    logic [31:0] d13;
    logic [31:0] d12;
  } job_t;

  typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DIV, PH_OUT} phase_t;
  typedef enum logic [1:0] {MD_FORM, MD_RANGE, MD_SCALE, MD_HUND} mode_t;

endpackage

>>> rtl/lc_value_from_oscillator_counts_core.sv
// Top level: configuration registers, front end, job queue and back end.
// On error or loaded count above open count the back end skips the arithmetic; otherwise
// the work is set by the 32-bit limb multiplier (6 to 8 products for capacitance, 12 to
// 14 for inductance) and up to 17 divide steps.
// The back end takes one item per run; queue holds two.
// Reset (rst, synchronous): registers take their defaults, queue and output empty.
module lc_value_from_oscillator_counts_core import lcv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // measured_count
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // reading[15:0], unit_code[18:16], zero pad
  output logic [1:0]  m_tuser,   // saturated[0], math_error[1]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  job_t        fjob, head;
  logic        full, jvalid, pop;
  logic [15:0] reading;
  logic [2:0]  unit;
  logic        sat, err;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.f1 <= 16'd65535;
      cfg.f2 <= 16'd1;
      cfg.cc <= 16'd1000;
      cfg.gate <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPEN: cfg.f1 <= cfg_data;
        REG_LOADED: cfg.f2 <= cfg_data;
        REG_CCAL: cfg.cc <= cfg_data;
        REG_GATE: cfg.gate <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = !full;

  lcv_front u_front (
    .cfg(cfg), .op(s_tuser), .count(s_tdata), .job(fjob)
  );

  lcv_fifo u_fifo (
    .clk(clk), .rst(rst), .wr(s_tvalid && !full), .wdata(fjob), .full(full),
    .rd(pop), .valid(jvalid), .rdata(head)
  );

  lcv_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .job_valid(jvalid), .head(head), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .o_reading(reading), .o_unit(unit),
    .o_sat(sat), .o_err(err)
  );

  assign m_tdata = {5'd0, unit, reading};
  assign m_tuser = {err, sat};

endmodule

>>> rtl/lcv_front.sv
// Front end: clamp the count, square the counts, flag errors.
module lcv_front import lcv_pkg::*; (
  input  cfg_t        cfg,
  input  logic        op,
  input  logic [15:0] count,
  output job_t        job
);

  logic [15:0] f3;

  always_comb begin
    f3 = (count > cfg.f1) ? cfg.f1 : count;
    job.op = op;
    job.s1 = cfg.f1 * cfg.f1;
    job.s2 = cfg.f2 * cfg.f2;
    job.s3 = f3 * f3;
    job.d13 = job.s1 - job.s3;
    job.neg = cfg.f2 > cfg.f1;
    job.d12 = job.neg ? (job.s2 - job.s1) : (job.s1 - job.s2);
    job.err = (f3 == 16'd0) || (cfg.f1 == cfg.f2) ||
              ((op == OP_IND) && ((cfg.f2 == 16'd0) || (cfg.cc == 16'd0)));
  end

endmodule

>>> rtl/lcv_fifo.sv
// Two-entry job queue between front and back.
module lcv_fifo import lcv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wdata,
  output logic full,
  input  logic rd,
  output logic valid,
  output job_t rdata
);

  job_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign valid = cnt != 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> rtl/lcv_back.sv
// Back end: wide products, auto-ranging and quotient, result register.
module lcv_back import lcv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        job_valid,
  input  job_t        head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] o_reading,
  output logic [2:0]  o_unit,
  output logic        o_sat,
  output logic        o_err
);

  typedef struct packed {
    logic        load;
    logic [31:0] lval;
    logic [31:0] factor;
    logic        store_n;
    logic        store_d;
    logic        last;
  } step_t;

  phase_t phase, phase_next;
  mode_t  mode;
  job_t   job;
  logic [3:0]  pc;
  logic [1:0]  k;
  logic [LIMBS-1:0][31:0] acc;
  logic [LIMBS-1:0][31:0] acc_upd;
  logic [31:0] m;
  logic [2:0]  idx;
  logic [31:0] carry;
  logic [63:0] prod;
  logic [BIG_W-1:0] nreg, dreg, ysh;
  logic [4:0]  cnt;
  logic [15:0] q;
  logic [15:0] r_reading;
  logic [2:0]  r_unit;
  logic        r_sat, r_err;
  logic        slot_free, mul_end, ge, gt;
  step_t       st0, stn;

  function automatic step_t step_of(input job_t j, input logic [3:0] p, input cfg_t c);
    step_t s;
    s = '0;
    if (j.op == OP_CAP) begin
      case (p)
        4'd0: begin s.load = 1'b1; s.lval = j.s2; s.factor = j.d13; end
        4'd1: begin s.factor = {16'd0, c.cc}; s.store_n = 1'b1; end
        default: begin
          s.load = 1'b1; s.lval = j.s3; s.factor = j.d12; s.store_d = 1'b1; s.last = 1'b1;
        end
      endcase
    end else begin
      case (p)
        4'd0: begin s.load = 1'b1; s.lval = j.d13; s.factor = j.d12; end
        4'd1: s.factor = {12'd0, 20'(c.gate * c.gate)};
        4'd2: s.factor = E9;
        4'd3: s.factor = E6;
        4'd4: begin s.factor = Q24_ONE; s.store_n = 1'b1; end
        4'd5: begin s.load = 1'b1; s.lval = FOUR_PI_SQ_Q24; s.factor = j.s1; end
        4'd6: s.factor = j.s2;
        4'd7: s.factor = j.s3;
        default: begin
          s.factor = {16'd0, c.cc}; s.store_d = 1'b1; s.last = 1'b1;
        end
      endcase
    end
    return s;
  endfunction

  function automatic logic [31:0] limit_of(input logic [1:0] i);
    case (i)
      2'd0: return LIM0;
      2'd1: return LIM1;
      default: return LIM2;
    endcase
  endfunction

  function automatic logic [31:0] scale_of(input logic [1:0] i);
    case (i)
      2'd0: return SC0;
      2'd1: return SC1;
      2'd2: return SC2;
      default: return SC3;
    endcase
  endfunction

  assign slot_free = !m_tvalid || m_tready;
  assign prod = acc[idx] * m + {32'd0, carry};
  assign mul_end = idx == 3'(LIMBS - 1);
  assign ge = acc >= ysh;
  assign gt = nreg > acc_upd;
  assign st0 = step_of(head, 4'd0, cfg);
  assign stn = step_of(job, pc + 4'd1, cfg);

  always_comb begin
    acc_upd = acc;
    acc_upd[idx] = prod[31:0];
  end

  always_comb begin
    phase_next = phase;
    pop = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (job_valid) begin
          pop = 1'b1;
          phase_next = (head.err || head.neg) ? PH_OUT : PH_MUL;
        end
      end
      PH_MUL: begin
        if (mul_end && mode == MD_HUND) begin
          phase_next = PH_DIV;
        end
      end
      PH_DIV: begin
        if ((cnt == 5'd16 && ge) || cnt == 5'd0) begin
          phase_next = PH_OUT;
        end
      end
      PH_OUT: begin
        if (slot_free) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        job <= head;
        pc <= 4'd0;
        mode <= MD_FORM;
        k <= 2'd0;
        acc <= BIG_W'(st0.lval);
        m <= st0.factor;
        idx <= 3'd0;
        carry <= 32'd0;
        r_reading <= 16'd0;
        r_unit <= (head.op == OP_IND) ? UNIT_NH : UNIT_PF;
        r_sat <= 1'b0;
        r_err <= head.err;
      end
      PH_MUL: begin
        idx <= idx + 3'd1;
        if (!mul_end) begin
          acc <= acc_upd;
          carry <= prod[63:32];
        end else begin
          carry <= 32'd0;
          case (mode)
            MD_FORM: begin
              if (step_of(job, pc, cfg).store_n) begin
                nreg <= acc_upd;
              end
              if (step_of(job, pc, cfg).last) begin
                acc <= acc_upd;
                dreg <= acc_upd;
                mode <= MD_RANGE;
                m <= LIM0;
              end else begin
                pc <= pc + 4'd1;
                m <= stn.factor;
                acc <= stn.load ? BIG_W'(stn.lval) : acc_upd;
              end
            end
            MD_RANGE: begin
              acc <= dreg;
              if (gt && k != 2'd2) begin
                k <= k + 2'd1;
                m <= limit_of(k + 2'd1);
              end else begin
                k <= gt ? k + 2'd1 : k;
                m <= scale_of(gt ? k + 2'd1 : k);
                mode <= MD_SCALE;
              end
            end
            MD_SCALE: begin
              ysh <= acc_upd << 16;
              acc <= nreg;
              m <= HUNDRED;
              mode <= MD_HUND;
            end
            default: begin
              acc <= acc_upd;
              cnt <= 5'd16;
              q <= 16'd0;
              r_unit <= r_unit - {1'b0, k};
            end
          endcase
        end
      end
      PH_DIV: begin
        ysh <= ysh >> 1;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd16) begin
          if (ge) begin
            r_reading <= 16'hFFFF;
            r_sat <= 1'b1;
          end
        end else begin
          if (ge) begin
            acc <= acc - ysh;
          end
          q[cnt[3:0]] <= ge;
          if (cnt == 5'd0) begin
            r_reading <= {q[15:1], ge};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (phase == PH_OUT && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_OUT && slot_free) begin
      o_reading <= r_reading;
      o_unit <= r_unit;
      o_sat <= r_sat;
      o_err <= r_err;
    end
  end

endmodule
